[hdl/drone_control_frame_scheduler_assert.svh]
// Assertion macros shared by the frame scheduler RTL.
`ifndef DRONE_CONTROL_FRAME_SCHEDULER_ASSERT_SVH
`define DRONE_CONTROL_FRAME_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, muted during rst.
`define DCFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted during rst.
`define DCFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dcfs_pkg.sv]
// Types, constants and mapping tables of the drone control frame scheduler.
package dcfs_pkg;

  localparam int DCFS_QUEUE_DEPTH = 2;

  localparam logic [15:0] AXIS_HOLD_RESET    = 16'd300;
  localparam logic [15:0] COMMAND_HOLD_RESET = 16'd1200;
  localparam logic [7:0]  ONESHOT_RESET      = 8'd20;
  localparam logic [15:0] TICK_PERIOD_RESET  = 16'd40;

  localparam logic [7:0] FRAME_HEAD = 8'h66;
  localparam logic [7:0] FRAME_TAIL = 8'h99;
  localparam int         FRAME_LEN  = 8;
  localparam int         POS_W      = $clog2(FRAME_LEN);

  localparam logic [7:0] FLAG_BITS [4] = '{8'h01, 8'h02, 8'h04, 8'h80};

  typedef enum logic [1:0] {
    REQ_AXIS      = 2'd0,
    REQ_COMMAND   = 2'd1,
    REQ_KEEPALIVE = 2'd2,
    REQ_TICK      = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    CFG_AXIS_HOLD    = 2'd0,
    CFG_COMMAND_HOLD = 2'd1,
    CFG_ONESHOT      = 2'd2,
    CFG_TICK_PERIOD  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] axis_hold_ms;
    logic [15:0] command_hold_ms;
    logic [7:0]  oneshot_repeat;
    logic [15:0] tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] roll;
    logic [7:0] pitch;
    logic [7:0] throttle;
    logic [7:0] yaw;
    logic [7:0] flags;
    logic [7:0] check;
  } frame_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef logic [7:0] center_lut_t [0:200];
  typedef logic [7:0] throttle_lut_t [0:100];

  // Bump a byte that would look like a frame marker.
  function automatic logic [7:0] avoid_markers(input logic [7:0] b);
    return (b == FRAME_HEAD || b == FRAME_TAIL) ? b + 8'd1 : b;
  endfunction

  // Entry i holds the byte for stick value i-100, rounded half up.
  function automatic center_lut_t center_lut_build();
    center_lut_t t;
    for (int i = 0; i <= 200; i++) begin
      t[i] = avoid_markers(8'(((i * 255) + 100) / 200));
    end
    return t;
  endfunction

  function automatic throttle_lut_t throttle_lut_build();
    throttle_lut_t t;
    for (int i = 0; i <= 100; i++) begin
      t[i] = 8'(((i * 255) + 50) / 100);
    end
    return t;
  endfunction

  localparam center_lut_t   CENTER_LUT   = center_lut_build();
  localparam throttle_lut_t THROTTLE_LUT = throttle_lut_build();

endpackage

[hdl/dcfs_if.sv]
// Handshake interfaces for the request and frame byte channels.
interface dcfs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         channel;
  logic signed [15:0] value;

  modport source(output valid, req_type, channel, value, input ready);
  modport sink(input valid, req_type, channel, value, output ready);
endinterface

interface dcfs_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

[hdl/dcfs_front.sv]
// Front end: takes requests, keeps control state, builds frames on sending ticks.
module dcfs_front import dcfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  dcfs_req_if.sink  req,
  input  q_status_t q_status,
  output logic      push,
  output frame_t    push_data
);

  logic signed [15:0] stick [4];
  logic [7:0]         counter [4];
  logic               keepalive_on;
  logic               activity_seen;
  logic [15:0]        hold_ms;

  logic               accept;
  logic signed [15:0] prev;
  logic               send;
  logic               any_counter;
  logic [15:0]        hold_dec;
  logic [7:0]         flags;
  logic [7:0]         roll_b, pitch_b, thr_b, yaw_b;

  function automatic logic [7:0] center_index(input logic signed [15:0] v);
    logic [7:0] r;
    if (v < -16'sd100) r = 8'd0;
    else if (v > 16'sd100) r = 8'd200;
    else r = v[7:0] + 8'd100;
    return r;
  endfunction

  function automatic logic [6:0] throttle_index(input logic signed [15:0] v);
    logic [6:0] r;
    if (v < 16'sd0) r = 7'd0;
    else if (v > 16'sd100) r = 7'd100;
    else r = v[6:0];
    return r;
  endfunction

  function automatic logic moving(input logic signed [15:0] v);
    return (v > 16'sd1) || (v < -16'sd1);
  endfunction

  function automatic logic [15:0] extend(input logic [15:0] cur, input logic [15:0] amt);
    return (amt > cur) ? amt : cur;
  endfunction

  assign req.ready = !q_status.full;
  assign accept    = req.valid && req.ready;
  assign prev      = stick[req.channel];

  always_comb begin
    any_counter = 1'b0;
    flags       = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (counter[i] != 8'd0) begin
        any_counter = 1'b1;
        flags       = flags | FLAG_BITS[i];
      end
    end
  end

  assign send = keepalive_on || (hold_ms != 16'd0) || any_counter || (stick[0] > 16'sd0)
             || moving(stick[1]) || moving(stick[2]) || moving(stick[3]);

  assign hold_dec = (hold_ms > cfg.tick_period_ms) ? hold_ms - cfg.tick_period_ms : 16'd0;

  assign roll_b  = CENTER_LUT[center_index(stick[3])];
  assign pitch_b = CENTER_LUT[center_index(stick[2])];
  assign thr_b   = THROTTLE_LUT[throttle_index(stick[0])];
  assign yaw_b   = CENTER_LUT[center_index(stick[1])];

  assign push_data.roll     = roll_b;
  assign push_data.pitch    = pitch_b;
  assign push_data.throttle = thr_b;
  assign push_data.yaw      = yaw_b;
  assign push_data.flags    = flags;
  assign push_data.check    = avoid_markers(roll_b ^ pitch_b ^ thr_b ^ yaw_b ^ flags);

  assign push = accept && (req_kind_t'(req.req_type) == REQ_TICK) && send;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        stick[i]   <= '0;
        counter[i] <= '0;
      end
      keepalive_on  <= 1'b1;
      activity_seen <= 1'b0;
      hold_ms       <= '0;
    end else if (accept) begin
      case (req_kind_t'(req.req_type))
        REQ_AXIS: begin
          stick[req.channel] <= req.value;
          if (req.value != prev) begin
            if (req.value != 16'sd0) begin
              activity_seen <= 1'b1;
              hold_ms       <= extend(hold_ms, cfg.axis_hold_ms);
            end else if (activity_seen) begin
              hold_ms <= extend(hold_ms, cfg.axis_hold_ms);
            end
          end
        end
        REQ_COMMAND: begin
          if (req.value > 16'sd0) begin
            activity_seen        <= 1'b1;
            counter[req.channel] <= cfg.oneshot_repeat;
            hold_ms              <= extend(hold_ms, cfg.command_hold_ms);
          end
        end
        REQ_KEEPALIVE: begin
          keepalive_on <= (req.value > 16'sd0);
          if (req.value > 16'sd0) activity_seen <= 1'b1;
        end
        REQ_TICK: begin
          hold_ms <= hold_dec;
          if (send) begin
            for (int i = 0; i < 4; i++) begin
              if (counter[i] != 8'd0) counter[i] <= counter[i] - 8'd1;
            end
          end else begin
            activity_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/dcfs_queue.sv]
// Short frame queue between the front end and the byte serializer.
module dcfs_queue import dcfs_pkg::*; #(
  parameter int DEPTH = DCFS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  frame_t    push_data,
  input  logic      pop,
  output frame_t    pop_data,
  output q_status_t q_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             slot [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop_data           = slot[rd_ptr];
  assign q_status.full      = (count == CNT_W'(DEPTH));
  assign q_status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/dcfs_back.sv]
// Back end: walks one queued frame out as eight bytes through an output register.
module dcfs_back import dcfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  frame_t      pop_data,
  input  q_status_t   q_status,
  output logic        pop,
  dcfs_frame_if.source frame
);

  localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ROLL  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PITCH = POS_W'(2);
  localparam logic [POS_W-1:0] POS_THR   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_YAW   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(5);
  localparam logic [POS_W-1:0] POS_CHECK = POS_W'(6);
  localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(FRAME_LEN - 1);

  frame_t           cur;
  logic             have_frame;
  logic [POS_W-1:0] pos;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             advance;
  logic             at_tail;
  logic [7:0]       sel_byte;

  assign advance = !out_valid || frame.ready;
  assign at_tail = (pos == POS_TAIL);
  assign pop     = q_status.not_empty && (!have_frame || (advance && at_tail));

  always_comb begin
    case (pos)
      POS_HEAD:  sel_byte = FRAME_HEAD;
      POS_ROLL:  sel_byte = cur.roll;
      POS_PITCH: sel_byte = cur.pitch;
      POS_THR:   sel_byte = cur.throttle;
      POS_YAW:   sel_byte = cur.yaw;
      POS_FLAGS: sel_byte = cur.flags;
      POS_CHECK: sel_byte = cur.check;
      default:   sel_byte = FRAME_TAIL;
    endcase
  end

  assign frame.valid      = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.last_byte  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_frame <= 1'b0;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= have_frame;
        if (have_frame) begin
          out_byte <= sel_byte;
          out_last <= at_tail;
        end
      end
      if (pop) begin
        cur        <= pop_data;
        have_frame <= 1'b1;
        pos        <= '0;
      end else if (advance && have_frame) begin
        pos <= pos + 1'b1;
        if (at_tail) have_frame <= 1'b0;
      end
    end
  end

endmodule

[hdl/drone_control_frame_scheduler.sv]
// Top level of the drone control frame scheduler: config registers, front, queue, back.
//
//  channel  | role   | payload                                    | notes
//  ---------+--------+--------------------------------------------+-------------------------
//  req      | sink   | req_type[1:0] channel[1:0] value[15:0] s   | ready low when queue full
//  frame    | source | frame_byte[7:0] last_byte                  | one byte per transaction
//  cfg_*    | write  | cfg_we cfg_index[1:0] cfg_data[15:0]       | no read-back
//
// Each request is taken as one transaction; axis, command and keepalive requests
// produce nothing. A sending tick leaves eight byte transactions, one per cycle
// while frame.ready is high, and a stream of sending ticks is paced by the single
// byte serializer. The frame queue (QUEUE_DEPTH entries) lets ticks be taken while
// the serializer is busy; once it is full, req.ready drops. Synchronous reset
// restores the register defaults and the control state.
`include "drone_control_frame_scheduler_assert.svh"

module drone_control_frame_scheduler import dcfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DCFS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dcfs_req_if.sink    req,
  dcfs_frame_if.source frame
);

  // Configuration registers, to be written only while the block is idle; the block does not enforce it.
  logic [15:0] axis_hold_ms;
  logic [15:0] command_hold_ms;
  logic [7:0]  oneshot_repeat;
  logic [15:0] tick_period_ms;
  cfg_t        cfg;

  // Queue handshake between front and back.
  logic      push;
  frame_t    push_data;
  logic      pop;
  frame_t    pop_data;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_hold_ms    <= AXIS_HOLD_RESET;
      command_hold_ms <= COMMAND_HOLD_RESET;
      oneshot_repeat  <= ONESHOT_RESET;
      tick_period_ms  <= TICK_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_AXIS_HOLD:    axis_hold_ms    <= cfg_data;
        CFG_COMMAND_HOLD: command_hold_ms <= cfg_data;
        CFG_ONESHOT:      oneshot_repeat  <= cfg_data[7:0];
        CFG_TICK_PERIOD:  tick_period_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.axis_hold_ms    = axis_hold_ms;
  assign cfg.command_hold_ms = command_hold_ms;
  assign cfg.oneshot_repeat  = oneshot_repeat;
  assign cfg.tick_period_ms  = tick_period_ms;

  // Front: update state on every request, build a frame on a sending tick.
  dcfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Hold finished frames until the serializer is free.
  dcfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // Back: advance one byte per accepted output transaction.
  dcfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .q_status (q_status),
    .pop      (pop),
    .frame    (frame)
  );

  `DCFS_ASSERT_IMP(a_no_push_full, push, !q_status.full, "frame pushed into a full queue")
  `DCFS_ASSERT_IMP(a_no_pop_empty, pop, q_status.not_empty, "frame popped from an empty queue")
  `DCFS_ASSERT_NXT(a_push_fills, push && !pop, q_status.not_empty, "pushed frame not held")
  `DCFS_ASSERT_IMP(a_tail_marker, frame.valid && frame.last_byte, frame.frame_byte == FRAME_TAIL, "last byte is not the tail marker")

endmodule

[bench/drone_control_frame_scheduler_test.sv]
// Self-checking testbench for the drone control frame scheduler.
module drone_control_frame_scheduler_test import dcfs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Stick channels of an axis request.
  localparam logic [1:0] AXIS_THROTTLE = 2'd0;
  localparam logic [1:0] AXIS_YAW      = 2'd1;
  localparam logic [1:0] AXIS_PITCH    = 2'd2;
  localparam logic [1:0] AXIS_ROLL     = 2'd3;

  // Command channels of a one-shot request.
  localparam logic [1:0] CMD_TAKEOFF   = 2'd0;
  localparam logic [1:0] CMD_LAND      = 2'd1;
  localparam logic [1:0] CMD_EMERGENCY = 2'd2;
  localparam logic [1:0] CMD_CALIBRATE = 2'd3;

  // Cycles to let pass after the last byte before touching the registers, and at the end.
  localparam int SETTLE_CYCLES = 40;

  // Mirror of the scheduler state; predicts the bytes of each sending tick and
  // checks every byte transaction against the oldest prediction.
  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } frame_beat_t;

    logic [15:0] axis_hold;
    logic [15:0] command_hold;
    logic [7:0]  oneshot_reload;
    logic [15:0] tick_period;

    int          sticks [4];
    logic [7:0]  shots [4];
    bit          keepalive;
    bit          active;
    logic [15:0] hold;

    frame_beat_t pending_beats [$];
    int          mismatches;
    int          requests;
    int          frames;
    int          silent_ticks;
    int          beats_checked;

    function new();
      axis_hold      = AXIS_HOLD_RESET;
      command_hold   = COMMAND_HOLD_RESET;
      oneshot_reload = ONESHOT_RESET;
      tick_period    = TICK_PERIOD_RESET;
      for (int i = 0; i < 4; i++) begin
        sticks[i] = 0;
        shots[i]  = 8'd0;
      end
      keepalive     = 1'b1;
      active        = 1'b0;
      hold          = 16'd0;
      mismatches    = 0;
      requests      = 0;
      frames        = 0;
      silent_ticks  = 0;
      beats_checked = 0;
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function int pending();
      return pending_beats.size();
    endfunction

    function void set_register(input cfg_index_t idx, input logic [15:0] data);
      case (idx)
        CFG_AXIS_HOLD:    axis_hold = data;
        CFG_COMMAND_HOLD: command_hold = data;
        CFG_ONESHOT:      oneshot_reload = data[7:0];
        CFG_TICK_PERIOD:  tick_period = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] dodge_marker(input logic [7:0] b);
      if (b == FRAME_HEAD || b == FRAME_TAIL) return b + 8'd1;
      return b;
    endfunction

    function logic [7:0] centered_byte(input int v);
      int c;
      int r;
      c = (v < -100) ? -100 : (v > 100) ? 100 : v;
      r = ((c + 100) * 255 + 100) / 200;
      return dodge_marker(r[7:0]);
    endfunction

    function logic [7:0] throttle_byte(input int v);
      int c;
      int r;
      c = (v < 0) ? 0 : (v > 100) ? 100 : v;
      r = (c * 255 + 50) / 100;
      return r[7:0];
    endfunction

    function bit off_center(input int v);
      return (v < -1) || (v > 1);
    endfunction

    function void lift_hold(input logic [15:0] amount);
      if (amount > hold) hold = amount;
    endfunction

    function void push_beat(input logic [7:0] data, input logic last);
      frame_beat_t beat;
      beat.data = data;
      beat.last = last;
      pending_beats.push_back(beat);
    endfunction

    function void note_request(input req_kind_t kind, input logic [1:0] ch,
                               input logic signed [15:0] value);
      int         v;
      int         prev;
      bit         send;
      logic [7:0] body [1:5];
      logic [7:0] flags;
      logic [7:0] sum;
      v = value;
      requests++;
      case (kind)
        REQ_AXIS: begin
          prev = sticks[ch];
          sticks[ch] = v;
          if (v != prev) begin
            if (v != 0) begin
              active = 1'b1;
              lift_hold(axis_hold);
            end else if (prev != 0 && active) begin
              lift_hold(axis_hold);
            end
          end
        end
        REQ_COMMAND: begin
          if (v > 0) begin
            active = 1'b1;
            shots[ch] = oneshot_reload;
            lift_hold(command_hold);
          end
        end
        REQ_KEEPALIVE: begin
          keepalive = (v > 0);
          if (keepalive) active = 1'b1;
        end
        default: begin
          send = keepalive || hold != 16'd0
              || shots[0] != 8'd0 || shots[1] != 8'd0
              || shots[2] != 8'd0 || shots[3] != 8'd0
              || sticks[AXIS_THROTTLE] > 0 || off_center(sticks[AXIS_YAW])
              || off_center(sticks[AXIS_PITCH]) || off_center(sticks[AXIS_ROLL]);
          hold = (hold > tick_period) ? hold - tick_period : 16'd0;
          if (!send) begin
            active = 1'b0;
            silent_ticks++;
          end else begin
            flags = 8'd0;
            for (int i = 0; i < 4; i++) begin
              if (shots[i] != 8'd0) begin
                flags |= FLAG_BITS[i];
                shots[i] = shots[i] - 8'd1;
              end
            end
            body[1] = centered_byte(sticks[AXIS_ROLL]);
            body[2] = centered_byte(sticks[AXIS_PITCH]);
            body[3] = throttle_byte(sticks[AXIS_THROTTLE]);
            body[4] = centered_byte(sticks[AXIS_YAW]);
            body[5] = flags;
            sum = dodge_marker(body[1] ^ body[2] ^ body[3] ^ body[4] ^ body[5]);
            push_beat(FRAME_HEAD, 1'b0);
            for (int i = 1; i <= 5; i++) push_beat(body[i], 1'b0);
            push_beat(sum, 1'b0);
            push_beat(FRAME_TAIL, 1'b1);
            frames++;
          end
        end
      endcase
    endfunction

    task check_beat(input logic [7:0] data, input logic last);
      frame_beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("byte %02h (last %0b) arrived with nothing expected", data, last));
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (data !== want.data)
          report($sformatf("frame_byte %02h, expected %02h", data, want.data));
        if (last !== want.last)
          report($sformatf("last_byte %0b, expected %0b", last, want.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  dcfs_req_if   req_ch ();
  dcfs_frame_if frame_ch ();

  frame_scoreboard board;

  // Percent of cycles in which each side idles; set per phase by the main sequence.
  int sender_idle_pct;
  int receiver_idle_pct;
  // Long receiver hold-off: the main sequence asks, the receiver process counts it down.
  int hold_off_request;
  int hold_off_left;

  drone_control_frame_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .frame     (frame_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watch both channels. Check the byte first: a request taken at this edge
  // cannot have produced bytes yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready)
        board.check_beat(frame_ch.frame_byte, frame_ch.last_byte);
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_kind_t'(req_ch.req_type), req_ch.channel, req_ch.value);
    end
  end

  // Receiver: take bytes at the phase's idle rate, or hold off completely while a
  // requested stall runs out.
  initial begin
    frame_ch.ready = 1'b0;
    hold_off_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_off_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Offer one request transaction, after a random idle gap, and hold it until taken.
  // Leave valid high on return so back-to-back requests follow without an idle gap.
  task automatic offer_request(input req_kind_t kind, input logic [1:0] ch, input int value);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.channel  <= ch;
    req_ch.value    <= 16'(value);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted byte, then let the block settle.
  task automatic drain_frames();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; call only while the block is idle.
  task automatic program_registers(input logic [15:0] axis_hold, input logic [15:0] cmd_hold,
                                   input logic [7:0] reload, input logic [15:0] period);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AXIS_HOLD;
    cfg_data <= axis_hold;
    @(posedge clk);
    board.set_register(CFG_AXIS_HOLD, axis_hold);
    cfg_index <= CFG_COMMAND_HOLD;
    cfg_data <= cmd_hold;
    @(posedge clk);
    board.set_register(CFG_COMMAND_HOLD, cmd_hold);
    cfg_index <= CFG_ONESHOT;
    cfg_data <= {8'd0, reload};
    @(posedge clk);
    board.set_register(CFG_ONESHOT, {8'd0, reload});
    cfg_index <= CFG_TICK_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    board.set_register(CFG_TICK_PERIOD, period);
    cfg_we <= 1'b0;
  endtask

  // One random request. Lean on ticks and on stick values near the clamp range so
  // both sending and silent ticks show up; keep some full-range noise.
  task automatic offer_random_request();
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 40) begin
      offer_request(REQ_TICK, 2'($urandom_range(3)), $urandom);
    end else if (pick < 70) begin
      case ($urandom_range(9))
        0, 1:    value = 0;
        2, 3, 4,
        5, 6:    value = $urandom_range(240) - 120;
        7:       value = $urandom_range(4) - 2;
        default: value = $urandom;
      endcase
      offer_request(REQ_AXIS, 2'($urandom_range(3)), value);
    end else if (pick < 85) begin
      value = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5, 1);
      offer_request(REQ_COMMAND, 2'($urandom_range(3)), value);
    end else begin
      value = ($urandom_range(2) == 0) ? $urandom_range(100, 1) : $urandom;
      if ($urandom_range(3) == 0) value = 0;
      offer_request(REQ_KEEPALIVE, 2'($urandom_range(3)), value);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_AXIS_HOLD;
    cfg_data = 16'd0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_AXIS;
    req_ch.channel = 2'd0;
    req_ch.value = 16'sd0;
    hold_off_request = 0;
    sender_idle_pct = 29;
    receiver_idle_pct = 70;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset register values.
    // Keepalive is on after reset, so the first tick sends a centered frame.
    offer_request(REQ_TICK, 2'd0, 0);
    // Keepalive off with nothing active: this tick stays silent.
    offer_request(REQ_KEEPALIVE, 2'd0, 0);
    offer_request(REQ_TICK, 2'd0, 0);
    // Throttle at the negative extreme: clamps to zero but still starts a hold.
    offer_request(REQ_AXIS, AXIS_THROTTLE, -32768);
    offer_request(REQ_TICK, 2'd0, 0);
    // Sticks at both extremes; yaw lands on the head marker and gets bumped.
    offer_request(REQ_AXIS, AXIS_THROTTLE, 32767);
    offer_request(REQ_AXIS, AXIS_ROLL, -32768);
    offer_request(REQ_AXIS, AXIS_PITCH, 32767);
    offer_request(REQ_AXIS, AXIS_YAW, -20);
    offer_request(REQ_TICK, 2'd0, 0);
    // Roll on the tail marker.
    offer_request(REQ_AXIS, AXIS_ROLL, 20);
    offer_request(REQ_TICK, 2'd0, 0);
    // Centered sticks, throttle 90: the checksum hits the head marker.
    offer_request(REQ_AXIS, AXIS_ROLL, 0);
    offer_request(REQ_AXIS, AXIS_PITCH, 0);
    offer_request(REQ_AXIS, AXIS_YAW, 0);
    offer_request(REQ_AXIS, AXIS_THROTTLE, 90);
    offer_request(REQ_TICK, 2'd0, 0);
    // Throttle 10 with takeoff and land flags: the checksum hits the tail marker.
    // Emergency with zero and calibrate with a negative value are ignored.
    offer_request(REQ_AXIS, AXIS_THROTTLE, 10);
    offer_request(REQ_COMMAND, CMD_TAKEOFF, 1);
    offer_request(REQ_COMMAND, CMD_LAND, 32767);
    offer_request(REQ_COMMAND, CMD_EMERGENCY, 0);
    offer_request(REQ_COMMAND, CMD_CALIBRATE, -5);
    offer_request(REQ_TICK, 2'd0, 0);
    offer_request(REQ_COMMAND, CMD_CALIBRATE, 1);
    offer_request(REQ_KEEPALIVE, 2'd0, 5);
    offer_request(REQ_TICK, 2'd0, 0);
    drain_frames();

    // Phase one: sender idles lightly, receiver heavily; both holds at zero, one-shot
    // repeat and tick period of one, so holds vanish and silent ticks are common.
    program_registers(16'd0, 16'd0, 8'd1, 16'd1);
    repeat (40) offer_random_request();
    drain_frames();

    // Phase two: idle rates swapped; every register at its maximum, so each change
    // holds but one tick period wipes the hold out again.
    sender_idle_pct = 70;
    receiver_idle_pct = 29;
    program_registers(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    repeat (40) offer_random_request();
    drain_frames();

    // Phase three: no idling, moderate random registers with a zero repeat count.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    program_registers(16'($urandom_range(200)), 16'($urandom_range(400)), 8'd0,
                      16'($urandom_range(100, 1)));
    // Stall the receiver for a long stretch while sending ticks keep coming, so the
    // frame queue fills and the request channel backs up.
    hold_off_request = 300;
    offer_request(REQ_KEEPALIVE, 2'd0, 1);
    repeat (12) offer_request(REQ_TICK, 2'd0, 0);
    repeat (40) offer_random_request();

    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 20000 && board.pending() > 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() > 0)
      board.report($sformatf("%0d expected bytes never arrived", board.pending()));

    $display("Covered %0d requests: %0d frames (%0d bytes checked), %0d silent ticks,",
             board.requests, board.frames, board.beats_checked, board.silent_ticks);
    $display("over three idle/stall mixes, register extremes and one long output stall.");
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
